// ===== hw/rtl/nck_pkg.sv =====
// ----------------------------------------------------------------------------
// nck_pkg
// Shared types, character codes and the hex digit decoder of the sentence
// checksum verifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nck_pkg;

  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;
  localparam logic [7:0] DigitOffset = 8'd10;

  localparam logic [1:0] DigitsExpected = 2'd2;
  localparam logic [1:0] CountMax       = 2'd3;

  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseBody   = 2'd1,
    PhaseDigits = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] running_xor;
    logic [7:0] received_value;
    logic [1:0] digit_count;
    logic       reject_flag;
  } state_t;

  localparam state_t StateReset = '{
    phase:          PhaseFirst,
    running_xor:    8'h00,
    received_value: 8'h00,
    digit_count:    2'd0,
    reject_flag:    1'b0
  };

  typedef struct packed {
    logic       sentence_valid;
    logic [7:0] computed_checksum;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.is_hex = 1'b1;
    h.nibble = 4'h0;
    if (b >= CharZero && b <= CharNine) begin
      h.nibble = 4'(b - CharZero);
    end else if (b >= CharUpperA && b <= CharUpperF) begin
      h.nibble = 4'(b - CharUpperA + DigitOffset);
    end else if (b >= CharLowerA && b <= CharLowerF) begin
      h.nibble = 4'(b - CharLowerA + DigitOffset);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/nck_if.sv =====
// ----------------------------------------------------------------------------
// nck_if
// Valid/ready channels for sentence bytes in and checksum results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_sentence;

  modport source (output valid, output data_byte, output end_of_sentence, input ready);
  modport sink   (input valid, input data_byte, input end_of_sentence, output ready);
endinterface

interface nck_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_valid;
  logic [7:0] computed_checksum;

  modport source (output valid, output sentence_valid, output computed_checksum, input ready);
  modport sink   (input valid, input sentence_valid, input computed_checksum, output ready);
endinterface

// ===== hw/rtl/nck_step.sv =====
// ----------------------------------------------------------------------------
// nck_step
// Per-byte update of the sentence state and the verdict on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nck_step (
  input  nck_pkg::state_t  state_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_sentence_i,
  output nck_pkg::state_t  state_o,
  output nck_pkg::result_t result_o
);
  import nck_pkg::*;

  hex_t   hex;
  state_t upd;
  logic   is_star;

  assign is_star = (data_byte_i == CharStar);

  always_comb begin
    upd = state_i;
    hex = hex_digit(data_byte_i);
    case (state_i.phase)
      PhaseFirst: begin
        if (is_star) begin
          upd.reject_flag = 1'b1;
          upd.phase       = PhaseDigits;
        end else begin
          if (data_byte_i != CharDollar) begin
            upd.reject_flag = 1'b1;
          end
          upd.phase = PhaseBody;
        end
      end
      PhaseBody: begin
        if (is_star) begin
          upd.phase = PhaseDigits;
        end else begin
          upd.running_xor = state_i.running_xor ^ data_byte_i;
        end
      end
      default: begin
        upd.phase = PhaseDigits;
        if (is_star || !hex.is_hex) begin
          upd.reject_flag = 1'b1;
        end else begin
          upd.received_value = {state_i.received_value[3:0], hex.nibble};
        end
        if (state_i.digit_count != CountMax) begin
          upd.digit_count = state_i.digit_count + 2'd1;
        end
      end
    endcase
  end

  always_comb begin
    result_o.sentence_valid = !upd.reject_flag && (upd.phase == PhaseDigits) &&
                              (upd.digit_count == DigitsExpected) &&
                              (upd.received_value == upd.running_xor);
    result_o.computed_checksum = upd.running_xor;
    state_o = end_of_sentence_i ? StateReset : upd;
  end

endmodule

// ===== hw/rtl/nmea_checksum_verifier.sv =====
// ----------------------------------------------------------------------------
// nmea_checksum_verifier
// Checks the checksum of a '$'-framed sentence that arrives one byte per
// request, the last byte flagged by end_of_sentence. Bytes between '$' and
// '*' are XORed and compared with the two hex digits after the '*'. One
// result (pass bit and computed XOR) appears for each sentence in the
// cycle after its last byte is taken. A byte is taken every cycle: the
// sentence state updates in a single registered pass, and the result
// register lets the next sentence keep flowing; in_i.ready drops only while
// a result is held and the sink is not ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_checksum_verifier (
  input  logic             clk_i,
  input  logic             rst_ni,
  nck_in_if.sink           in_i,
  nck_out_if.source        out_o
);
  import nck_pkg::*;

  state_t  state_q, state_d;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    accept;
  logic    emit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign emit       = accept && in_i.end_of_sentence;

  nck_step u_step (
    .state_i           (state_q),
    .data_byte_i       (in_i.data_byte),
    .end_of_sentence_i (in_i.end_of_sentence),
    .state_o           (state_d),
    .result_o          (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.sentence_valid    = result_q.sentence_valid;
  assign out_o.computed_checksum = result_q.computed_checksum;

endmodule

// ===== hw/rtl/nck_checker.sv =====
// ----------------------------------------------------------------------------
// nck_checker
// Port-level checks of the sentence checksum verifier, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nck_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_end_of_sentence_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_sentence_valid_i,
  input logic [7:0] out_computed_checksum_i
);

  logic last_accept;
  assign last_accept = in_valid_i && in_ready_i && in_end_of_sentence_i;

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_sentence_valid_i) && $stable(out_computed_checksum_i))
    else $error("result payload changed while stalled");

  // last byte of a sentence always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_accept |=> out_valid_i)
    else $error("no result after last byte");

  // a fresh result only follows a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(last_accept))
    else $error("result without a finished sentence");

  // input never blocked while no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind nmea_checksum_verifier nck_checker u_nck_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_i.valid),
  .in_ready_i              (in_i.ready),
  .in_end_of_sentence_i    (in_i.end_of_sentence),
  .out_valid_i             (out_o.valid),
  .out_ready_i             (out_o.ready),
  .out_sentence_valid_i    (out_o.sentence_valid),
  .out_computed_checksum_i (out_o.computed_checksum)
);

// ===== dv/tb_nmea_checksum_verifier.sv =====
// ----------------------------------------------------------------------------
// tb_nmea_checksum_verifier
// Self-checking bench for the sentence checksum verifier. Short directed
// sentences cover the framing errors, the digit count limits, both letter
// cases and the extreme byte values. Random sentences follow, most of them
// well formed and the rest mutated or pure noise. A scoreboard predicts the
// pass bit and the XOR of every sentence and checks each result in order.
// Both channels idle at random, and the result side holds off for long
// stretches so that the block backs up its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nmea_checksum_verifier;
  import nck_pkg::*;

  localparam int unsigned ByteTarget = 1050;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 120;

  typedef logic [7:0] byte_q_t[$];

  class checksum_scoreboard;
    phase_e     phase;
    logic [7:0] xor_acc;
    logic [7:0] digits;
    logic [1:0] count;
    logic       bad;
    result_t    verdicts_q[$];
    int         errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase   = PhaseFirst;
      xor_acc = 8'h00;
      digits  = 8'h00;
      count   = 2'd0;
      bad     = 1'b0;
    endfunction

    function bit decode_hex(input logic [7:0] b, output logic [3:0] v);
      v = 4'h0;
      if (b >= 8'h30 && b <= 8'h39) begin
        v = b[3:0];
        return 1'b1;
      end
      if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
        v = 4'(b[3:0] + 4'd9);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] b, input logic eos);
      logic [3:0] nib;
      result_t    r;
      case (phase)
        PhaseFirst: begin
          if (b == CharStar) begin
            bad   = 1'b1;
            phase = PhaseDigits;
          end else begin
            if (b != CharDollar) bad = 1'b1;
            phase = PhaseBody;
          end
        end
        PhaseBody: begin
          if (b == CharStar) phase = PhaseDigits;
          else xor_acc = xor_acc ^ b;
        end
        default: begin
          if (b == CharStar) bad = 1'b1;
          else if (!decode_hex(b, nib)) bad = 1'b1;
          else digits = {digits[3:0], nib};
          if (count != CountMax) count = count + 2'd1;
        end
      endcase
      if (eos) begin
        r.sentence_valid    = !bad && phase == PhaseDigits && count == DigitsExpected &&
                              digits == xor_acc;
        r.computed_checksum = xor_acc;
        verdicts_q.push_back(r);
        clear();
      end
    endfunction

    function void check_result(input logic ok, input logic [7:0] cks);
      result_t e;
      if (verdicts_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual valid=%0b checksum=%02h",
                 $time, ok, cks);
        errors++;
        return;
      end
      e = verdicts_q.pop_front();
      if (ok !== e.sentence_valid) begin
        $display("%0t: sentence_valid mismatch, expected %0b actual %0b",
                 $time, e.sentence_valid, ok);
        errors++;
      end
      if (cks !== e.computed_checksum) begin
        $display("%0t: computed_checksum mismatch, expected %02h actual %02h",
                 $time, e.computed_checksum, cks);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nck_in_if  byte_ch ();
  nck_out_if res_ch ();

  nmea_checksum_verifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  checksum_scoreboard sb;
  int unsigned        cycles;
  int unsigned        bytes_sent;
  bit                 steady;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("nmea_checksum_verifier regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return CharZero + 8'(n);
    return (upper ? CharUpperA : CharLowerA) + 8'(n) - DigitOffset;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid           <= 1'b1;
    byte_ch.data_byte       <= b;
    byte_ch.end_of_sentence <= eos;
    do @(posedge clk_i); while (!byte_ch.ready);
    sb.note_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_sentence(input byte_q_t s);
    steady = ($urandom_range(0, 7) == 0);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic receive_results();
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken == 20 || taken == 140) stall = LongHold;
      else stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      sb.check_result(res_ch.sentence_valid, res_ch.computed_checksum);
      taken++;
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return CharStar;
      1:       return CharDollar;
      2:       return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_q_t make_sentence();
    byte_q_t     s;
    logic [7:0]  x;
    logic [7:0]  b;
    logic [7:0]  ck;
    int          n;
    int          star_pos;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      n = $urandom_range(1, 12);
      repeat (n) s.push_back(noise_byte());
      return s;
    end
    x = 8'h00;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    s.push_back(CharDollar);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CharStar) b = 8'($urandom_range(0, 41));
      x = x ^ b;
      s.push_back(b);
    end
    star_pos = s.size();
    s.push_back(CharStar);
    ck = ($urandom_range(0, 3) != 0) ? x : 8'($urandom_range(0, 255));
    s.push_back(hex_char(ck[7:4], 1'($urandom_range(0, 1))));
    s.push_back(hex_char(ck[3:0], 1'($urandom_range(0, 1))));
    if (kind >= 75) begin
      case ($urandom_range(0, 5))
        0: s[0] = noise_byte();
        1: s.delete(s.size() - 1);
        2: s.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        3: s.insert($urandom_range(star_pos + 1, s.size()), CharStar);
        4: s[$urandom_range(star_pos + 1, s.size() - 1)] = noise_byte();
        default: s.delete(star_pos);
      endcase
    end
    return s;
  endfunction

  initial begin
    sb                      = new();
    cycles                  = 0;
    bytes_sent              = 0;
    steady                  = 1'b0;
    rst_ni                  = 1'b0;
    byte_ch.valid           = 1'b0;
    byte_ch.data_byte       = 8'h00;
    byte_ch.end_of_sentence = 1'b0;
    res_ch.ready            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      receive_results();
    join_none

    // well formed, lowercase digits, top byte value
    send_sentence({CharDollar, 8'hFF, CharStar, hex_char(4'hF, 1'b0), hex_char(4'hF, 1'b0)});
    // star first, then a second star
    send_sentence({CharStar, CharStar, hex_char(4'h0, 1'b1), hex_char(4'hA, 1'b1)});
    // bad first byte, no star
    send_sentence({8'h00, 8'h7A});
    // single byte
    send_sentence({CharDollar});
    // non-hex digit and three digits
    send_sentence({CharDollar, CharStar, 8'h47, hex_char(4'h0, 1'b1),
                   hex_char(4'h0, 1'b1)});
    // one digit only
    send_sentence({CharDollar, CharStar, hex_char(4'h0, 1'b1)});
    // well formed, uppercase digits
    send_sentence({CharDollar, 8'h5A, CharStar, hex_char(4'h5, 1'b1), hex_char(4'hA, 1'b1)});

    while (bytes_sent < ByteTarget) send_sentence(make_sentence());
    byte_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nmea_checksum_verifier regression: pass");
    end else begin
      $display("nmea_checksum_verifier regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nck_pkg.sv
hw/rtl/nck_if.sv
hw/rtl/nck_step.sv
hw/rtl/nmea_checksum_verifier.sv
hw/rtl/nck_checker.sv
dv/tb_nmea_checksum_verifier.sv
